// ----- rtl/core/fcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// fcfd_pkg
// Shared types and constants for the front-coded field decoder: command
// format between front and back, result format and prefix digit decoding.
// ----------------------------------------------------------------------------
package fcfd_pkg;

  // Character constants
  localparam logic [7:0] SEP_RESET  = 8'h23;  // '#'
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Counter ceilings
  localparam logic [7:0] FIELD_IDX_MAX = 8'd255;
  localparam logic [5:0] CHAR_IDX_MAX  = 6'd63;

  // Queue depths
  localparam int QUEUE_DEPTH = 4;
  localparam int OBUF_DEPTH  = 3;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_COPY,
    CMD_STAT
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_NEWLINE = 2'd1,
    ST_VERSION    = 2'd2,
    ST_BAD_PREFIX = 2'd3
  } status_t;

  // Work handed from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;     // byte to emit
    logic       wr_en;    // also save the byte in the field store
    logic [5:0] fidx;     // field number for store access
    logic [5:0] pos;      // byte position for a store write
    logic [5:0] cnt;      // bytes to copy
    status_t    status;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    status_t    status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } digit_t;

  // Map a prefix character to its value
  function automatic digit_t digit_decode(input logic [7:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d.val = 6'(c - CH_ZERO);
    end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      d.val = 6'(c - CH_UPPER_A + 8'd10);
    end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      d.val = 6'(c - CH_LOWER_A + 8'd36);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/front_coded_field_decoder.sv -----
// Result path: an accepted item passes through the command queue, the result stage
//   register and the output buffer before it shows at out_*.
// Throughput: one item per cycle; a prefix of value d takes d field-store reads in the
//   back end (one per cycle while the output buffer has room), and input stalls once the
//   four-entry command queue fills.
// Reset: synchronous, active low; clears counters, queues, halt flag; separator back to '#'.
// ----------------------------------------------------------------------------
// front_coded_field_decoder
// Front-coded line stream expander: front end classifies bytes and checks
// prefixes, back end emits bytes and replays copied prefixes.
// ----------------------------------------------------------------------------
module front_coded_field_decoder #(
  parameter int MAX_FIELDS    = 8,
  parameter int MAX_FIELD_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration: separator byte
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] end_of_input
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] byte_valid, [2:1] status
  output logic       out_tlast   // last
);

  logic               cmd_push;
  fcfd_pkg::cmd_t     cmd_in;
  fcfd_pkg::cmd_t     cmd_head;
  logic               q_valid;
  logic               q_full;
  logic               q_pop;
  logic [$clog2(fcfd_pkg::QUEUE_DEPTH+1)-1:0] q_count;
  fcfd_pkg::result_t  res;

  fcfd_front #(
    .MAX_FIELDS    (MAX_FIELDS),
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_eoi    (in_tuser[0]),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  fcfd_fifo #(
    .T     (fcfd_pkg::cmd_t),
    .DEPTH (fcfd_pkg::QUEUE_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (q_pop),
    .dout  (cmd_head),
    .valid (q_valid),
    .full  (q_full),
    .count (q_count)
  );

  fcfd_back #(
    .MAX_FIELDS    (MAX_FIELDS),
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (cmd_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Unpack the result
  assign out_tdata = res.data;
  assign out_tuser = {res.status, res.byte_valid};
  assign out_tlast = res.last;

  // Queue level is not needed beyond the full flag
  logic unused_count;
  assign unused_count = ^q_count;

endmodule

// ----- rtl/core/fcfd_fifo.sv -----
// ----------------------------------------------------------------------------
// fcfd_fifo
// Small register queue with occupancy count; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module fcfd_fifo #(
  parameter type T     = logic [7:0],
  parameter int  DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  T                           din,
  input  logic                       pop,
  output T                           dout,
  output logic                       valid,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // Advance pointers with wrap
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  assign dout  = mem_r[rp_r];
  assign valid = (cnt_r != '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign count = cnt_r;

endmodule

// ----- rtl/core/fcfd_front.sv -----
// ----------------------------------------------------------------------------
// fcfd_front
// Accepts input items, tracks line and field position, checks prefixes
// against saved field lengths and issues commands to the back end.
// ----------------------------------------------------------------------------
module fcfd_front #(
  parameter int MAX_FIELDS    = 8,
  parameter int MAX_FIELD_LEN = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_eoi,
  input  logic              q_full,
  output logic              cmd_push,
  output fcfd_pkg::cmd_t    cmd
);

  localparam int FIW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  logic [7:0] sep_r;
  logic [7:0] pfc_r, pfc_nxt;
  logic [7:0] fi_r, fi_nxt;
  logic [5:0] ci_r, ci_nxt;
  logic       exp_r, exp_nxt;
  logic       halted_r, halted_nxt;
  logic [5:0] len_r [MAX_FIELDS];

  logic              accept;
  logic              save_len;
  logic              fi_in_range;
  logic [7:0]        fi_inc;
  fcfd_pkg::digit_t  dig;

  assign in_ready    = !q_full;
  assign cfg_ready   = 1'b1;
  assign accept      = in_valid && in_ready;
  assign fi_in_range = (fi_r < 8'(MAX_FIELDS));
  assign fi_inc      = (fi_r == fcfd_pkg::FIELD_IDX_MAX) ? fi_r : fi_r + 8'd1;
  assign dig         = fcfd_pkg::digit_decode(in_byte);

  // Classify the item and build its command
  always_comb begin
    pfc_nxt    = pfc_r;
    fi_nxt     = fi_r;
    ci_nxt     = ci_r;
    exp_nxt    = exp_r;
    halted_nxt = halted_r;
    save_len   = 1'b0;
    cmd_push   = 1'b0;
    cmd        = '0;
    cmd.kind   = fcfd_pkg::CMD_BYTE;
    cmd.status = fcfd_pkg::ST_OK;
    cmd.fidx   = fi_r[5:0];
    cmd.pos    = ci_r;
    if (accept && !halted_r) begin
      if (in_eoi) begin
        cmd_push = 1'b1;
        cmd.kind = fcfd_pkg::CMD_STAT;
        if (fi_r != '0 || ci_r != '0) begin
          cmd.status = fcfd_pkg::ST_NO_NEWLINE;
          halted_nxt = 1'b1;
        end
      end else if (exp_r) begin
        if (dig.ok && dig.val == '0) begin
          // zero prefix: nothing to copy
          exp_nxt = 1'b0;
        end else if (!fi_in_range ||
                     (dig.ok && {1'b0, dig.val} > 7'(MAX_FIELD_LEN))) begin
          cmd_push   = 1'b1;
          cmd.kind   = fcfd_pkg::CMD_STAT;
          cmd.status = fcfd_pkg::ST_VERSION;
          halted_nxt = 1'b1;
        end else if (!dig.ok || dig.val > len_r[fi_r[FIW-1:0]]) begin
          cmd_push   = 1'b1;
          cmd.kind   = fcfd_pkg::CMD_STAT;
          cmd.status = fcfd_pkg::ST_BAD_PREFIX;
          halted_nxt = 1'b1;
        end else begin
          cmd_push = 1'b1;
          cmd.kind = fcfd_pkg::CMD_COPY;
          cmd.cnt  = dig.val;
          ci_nxt   = dig.val;
          exp_nxt  = 1'b0;
        end
      end else if (in_byte == sep_r) begin
        save_len = 1'b1;
        cmd_push = 1'b1;
        cmd.data = sep_r;
        fi_nxt   = fi_inc;
        ci_nxt   = '0;
        exp_nxt  = (fi_inc < pfc_r);
      end else if (in_byte == fcfd_pkg::NEWLINE) begin
        save_len = 1'b1;
        cmd_push = 1'b1;
        cmd.data = fcfd_pkg::NEWLINE;
        pfc_nxt  = fi_inc;
        fi_nxt   = '0;
        ci_nxt   = '0;
        exp_nxt  = 1'b1;
      end else begin
        cmd_push  = 1'b1;
        cmd.data  = in_byte;
        cmd.wr_en = fi_in_range && (ci_r < 6'(MAX_FIELD_LEN));
        ci_nxt    = (ci_r == fcfd_pkg::CHAR_IDX_MAX) ? ci_r : ci_r + 6'd1;
      end
    end
  end

  // Hold position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r    <= fcfd_pkg::SEP_RESET;
      pfc_r    <= '0;
      fi_r     <= '0;
      ci_r     <= '0;
      exp_r    <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sep_r <= cfg_data;
      end
      pfc_r    <= pfc_nxt;
      fi_r     <= fi_nxt;
      ci_r     <= ci_nxt;
      exp_r    <= exp_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Save the finished field's length
  always_ff @(posedge clk) begin
    if (save_len && fi_in_range) begin
      len_r[fi_r[FIW-1:0]] <= ci_r;
    end
  end

endmodule

// ----- rtl/core/fcfd_back.sv -----
// ----------------------------------------------------------------------------
// fcfd_back
// Executes commands: emits literal and status results, saves field bytes and replays
// prefix copies from the field store one byte per cycle while the output buffer has room.
// ----------------------------------------------------------------------------
module fcfd_back #(
  parameter int MAX_FIELDS    = 8,
  parameter int MAX_FIELD_LEN = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  fcfd_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output fcfd_pkg::result_t   out_res
);

  localparam int MEM_DEPTH = MAX_FIELDS * MAX_FIELD_LEN;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int OCW       = $clog2(fcfd_pkg::OBUF_DEPTH + 1);

  logic [7:0]         store_r [MEM_DEPTH];
  logic [7:0]         rdata_r;
  logic [5:0]         j_r, j_nxt;
  logic               b_v_r;
  logic               b_mem_r;
  fcfd_pkg::result_t  b_res_r;

  fcfd_pkg::result_t  res;
  fcfd_pkg::result_t  obuf_din;
  logic               from_mem;
  logic               wr;
  logic               issue;
  logic               copy_last;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [OCW-1:0]     obuf_count;
  logic               obuf_full;

  // Issue only while the output buffer has room for in-flight results
  assign issue = q_valid &&
                 ((3'(obuf_count) + 3'(b_v_r)) < 3'(fcfd_pkg::OBUF_DEPTH));
  assign copy_last = (j_r == q_cmd.cnt - 6'd1);
  assign wr_addr = AW'(32'(q_cmd.fidx) * MAX_FIELD_LEN + 32'(q_cmd.pos));
  assign rd_addr = AW'(32'(q_cmd.fidx) * MAX_FIELD_LEN + 32'(j_r));

  // Decode the head command
  always_comb begin
    q_pop          = 1'b0;
    from_mem       = 1'b0;
    wr             = 1'b0;
    j_nxt          = j_r;
    res            = '0;
    res.status     = fcfd_pkg::ST_OK;
    case (q_cmd.kind)
      fcfd_pkg::CMD_BYTE: begin
        res.data       = q_cmd.data;
        res.byte_valid = 1'b1;
        res.last       = 1'b1;
        wr             = q_cmd.wr_en;
        q_pop          = issue;
      end
      fcfd_pkg::CMD_STAT: begin
        res.status = q_cmd.status;
        res.last   = 1'b1;
        q_pop      = issue;
      end
      fcfd_pkg::CMD_COPY: begin
        from_mem       = 1'b1;
        res.byte_valid = 1'b1;
        res.last       = copy_last;
        if (issue) begin
          if (copy_last) begin
            q_pop = 1'b1;
            j_nxt = '0;
          end else begin
            j_nxt = j_r + 6'd1;
          end
        end
      end
      default: begin
        q_pop = issue;
      end
    endcase
  end

  // Field store: write literals, read copy bytes
  always_ff @(posedge clk) begin
    if (issue && wr) begin
      store_r[wr_addr] <= q_cmd.data;
    end
    if (issue && from_mem) begin
      rdata_r <= store_r[rd_addr];
    end
  end

  // Result stage payload
  always_ff @(posedge clk) begin
    if (issue) begin
      b_res_r <= res;
      b_mem_r <= from_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      j_r   <= '0;
    end else begin
      b_v_r <= issue;
      j_r   <= j_nxt;
    end
  end

  // Merge read data into the staged result
  always_comb begin
    obuf_din = b_res_r;
    if (b_mem_r) begin
      obuf_din.data = rdata_r;
    end
  end

  fcfd_fifo #(
    .T     (fcfd_pkg::result_t),
    .DEPTH (fcfd_pkg::OBUF_DEPTH)
  ) u_obuf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_v_r),
    .din   (obuf_din),
    .pop   (out_valid && out_ready),
    .dout  (out_res),
    .valid (out_valid),
    .full  (obuf_full),
    .count (obuf_count)
  );

  // Buffer never fills beyond credit; full only when all slots are used
  logic unused_full;
  assign unused_full = obuf_full;

endmodule

// ----- rtl/core/fcfd_checker.sv -----
// ----------------------------------------------------------------------------
// fcfd_checker
// Port-level checks on the result stream of the decoder.
// ----------------------------------------------------------------------------
module fcfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Status-only results carry no byte and close their item
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:1] != 2'(fcfd_pkg::ST_OK)) |->
      (!out_tuser[0] && out_tlast && out_tdata == 8'd0))
    else $error("malformed status result");

  // Nothing follows a delivered error
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser[2:1] != 2'(fcfd_pkg::ST_OK)) |=>
      !out_tvalid)
    else $error("result after error");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind front_coded_field_decoder fcfd_checker u_fcfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Front-coded field decoder testbench
// Streams front-coded lines into the decoder and checks every expanded byte
// and status result against an in-bench model of the line and field store.
// Covers directed corner lines, random well-formed lines under four idling
// mixes and several separators, a long output stall, counter saturation and
// one halting error per run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_FIELDS    = 8;
  localparam int MAX_FIELD_LEN = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = 8'h00;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic [0:0] in_tuser   = 1'b0;   // [0] end_of_input
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic [2:0] out_tuser;           // [0] byte_valid, [2:1] status
  logic       out_tlast;

  // Idling mix, in percent
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Long receiver hold-off request
  logic        hold_toggle = 1'b0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;

  int          error_count = 0;
  int unsigned cycle_count = 0;

  // Decoder model state
  logic [7:0] sep_byte;
  logic [7:0] saved_bytes [MAX_FIELDS][MAX_FIELD_LEN];
  logic [5:0] saved_len   [MAX_FIELDS];
  logic [7:0] prev_fields;
  logic [7:0] field_idx;
  logic [5:0] char_idx;
  logic       want_prefix;
  logic       is_halted;

  // Expanded results still to come out
  fcfd_pkg::result_t expansion_q[$];

  front_coded_field_decoder #(
    .MAX_FIELDS   (MAX_FIELDS),
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Value of a prefix character, -1 for a non-digit
  function automatic int digit_of(input logic [7:0] c);
    if (c >= fcfd_pkg::CH_ZERO && c <= fcfd_pkg::CH_NINE)
      return int'(c - fcfd_pkg::CH_ZERO);
    if (c >= fcfd_pkg::CH_UPPER_A && c <= fcfd_pkg::CH_UPPER_Z)
      return int'(c - fcfd_pkg::CH_UPPER_A) + 10;
    if (c >= fcfd_pkg::CH_LOWER_A && c <= fcfd_pkg::CH_LOWER_Z)
      return int'(c - fcfd_pkg::CH_LOWER_A) + 36;
    return -1;
  endfunction

  function automatic logic [7:0] prefix_char(input int unsigned v);
    if (v < 10) return fcfd_pkg::CH_ZERO + 8'(v);
    if (v < 36) return fcfd_pkg::CH_UPPER_A + 8'(v - 10);
    return fcfd_pkg::CH_LOWER_A + 8'(v - 36);
  endfunction

  function automatic logic [7:0] random_non_digit();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (digit_of(c) >= 0) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic fcfd_pkg::result_t make_result(input logic [7:0] b, input logic bv,
                                                    input fcfd_pkg::status_t st);
    fcfd_pkg::result_t r;
    r.data       = b;
    r.byte_valid = bv;
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic reset_model();
    sep_byte    = fcfd_pkg::SEP_RESET;
    prev_fields = '0;
    field_idx   = '0;
    char_idx    = '0;
    want_prefix = 1'b0;
    is_halted   = 1'b0;
    for (int f = 0; f < MAX_FIELDS; f++) begin
      saved_len[f] = '0;
      for (int k = 0; k < MAX_FIELD_LEN; k++) saved_bytes[f][k] = '0;
    end
  endtask

  task automatic save_field_len();
    if (field_idx < MAX_FIELDS) saved_len[field_idx] = char_idx;
  endtask

  // Expand one accepted item and queue the results it causes
  task automatic expand_item(input logic [7:0] c, input logic eoi);
    fcfd_pkg::result_t burst[$];
    int                d;
    if (is_halted) return;
    if (eoi) begin
      if (field_idx == 0 && char_idx == 0) begin
        burst.push_back(make_result(8'h00, 1'b0, fcfd_pkg::ST_OK));
      end else begin
        is_halted = 1'b1;
        burst.push_back(make_result(8'h00, 1'b0, fcfd_pkg::ST_NO_NEWLINE));
      end
    end else if (want_prefix) begin
      d = digit_of(c);
      if (d != 0) begin
        if (!(field_idx < MAX_FIELDS && d <= MAX_FIELD_LEN)) begin
          is_halted = 1'b1;
          burst.push_back(make_result(8'h00, 1'b0, fcfd_pkg::ST_VERSION));
        end else if (!(d > 0 && d <= int'(saved_len[field_idx]))) begin
          is_halted = 1'b1;
          burst.push_back(make_result(8'h00, 1'b0, fcfd_pkg::ST_BAD_PREFIX));
        end else begin
          for (int j = 0; j < d; j++)
            burst.push_back(make_result(saved_bytes[field_idx][j], 1'b1,
                                        fcfd_pkg::ST_OK));
          char_idx    = 6'(d);
          want_prefix = 1'b0;
        end
      end else begin
        want_prefix = 1'b0;
      end
    end else if (c == sep_byte) begin
      save_field_len();
      burst.push_back(make_result(sep_byte, 1'b1, fcfd_pkg::ST_OK));
      if (field_idx < fcfd_pkg::FIELD_IDX_MAX) field_idx++;
      char_idx    = '0;
      want_prefix = field_idx < prev_fields;
    end else if (c == fcfd_pkg::NEWLINE) begin
      save_field_len();
      prev_fields = (field_idx < fcfd_pkg::FIELD_IDX_MAX) ? field_idx + 8'd1 :
                                                           fcfd_pkg::FIELD_IDX_MAX;
      burst.push_back(make_result(fcfd_pkg::NEWLINE, 1'b1, fcfd_pkg::ST_OK));
      field_idx   = '0;
      char_idx    = '0;
      want_prefix = 1'b1;
    end else begin
      burst.push_back(make_result(c, 1'b1, fcfd_pkg::ST_OK));
      if (field_idx < MAX_FIELDS && char_idx < MAX_FIELD_LEN)
        saved_bytes[field_idx][char_idx] = c;
      if (char_idx < fcfd_pkg::CHAR_IDX_MAX) char_idx++;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) expansion_q.push_back(burst[i]);
  endtask

  // Offer one item, hold it until accepted, then expand it
  task automatic send_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expand_item(b, eoi);
  endtask

  // Send the next byte of a well-formed stream, guided by the model state
  task automatic send_coded_byte();
    int unsigned roll;
    int unsigned room;
    logic [7:0]  b;
    roll = $urandom_range(99);
    if (field_idx == 0 && char_idx == 0 && roll < 4) begin
      send_item(8'($urandom_range(255)), 1'b1);
    end else if (want_prefix) begin
      room = 0;
      if (field_idx < MAX_FIELDS)
        room = (saved_len[field_idx] < MAX_FIELD_LEN) ? saved_len[field_idx] :
                                                        MAX_FIELD_LEN;
      b = (roll < 35) ? prefix_char(room) : prefix_char($urandom_range(room));
      send_item(b, 1'b0);
    end else begin
      if (roll < 15) b = sep_byte;
      else if (roll < 19) b = fcfd_pkg::NEWLINE;
      else b = 8'($urandom_range(255));
      send_item(b, 1'b0);
    end
  endtask

  task automatic skip_prefix();
    if (want_prefix) send_item(fcfd_pkg::CH_ZERO, 1'b0);
  endtask

  task automatic end_line();
    skip_prefix();
    send_item(fcfd_pkg::NEWLINE, 1'b0);
  endtask

  // Drop valid and wait for every queued result to come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expansion_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sep_byte = value;
  endtask

  // Call only with valid low
  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    @(posedge clk);
  endtask

  // Corner lines: byte extremes, copies, zero prefix, clean end of stream
  task automatic test_directed_lines();
    set_idling(0, 0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(fcfd_pkg::SEP_RESET, 1'b0);
    send_item("c", 1'b0);
    send_item(fcfd_pkg::NEWLINE, 1'b0);
    send_item("2", 1'b0);
    send_item("q", 1'b0);
    send_item(fcfd_pkg::SEP_RESET, 1'b0);
    send_item(fcfd_pkg::CH_ZERO, 1'b0);
    send_item("Z", 1'b0);
    send_item(fcfd_pkg::NEWLINE, 1'b0);
    send_item(8'h00, 1'b1);
    send_item("3", 1'b0);
    send_item(fcfd_pkg::SEP_RESET, 1'b0);
    send_item("1", 1'b0);
    send_item(fcfd_pkg::NEWLINE, 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  task automatic test_random_lines(input logic [7:0] sep, input int unsigned send_pct,
                                   input int unsigned recv_pct, input int unsigned count);
    write_separator(sep);
    set_idling(send_pct, recv_pct);
    repeat (count) send_coded_byte();
  endtask

  // Stall the output for a long stretch while input keeps coming
  task automatic test_backpressure();
    write_separator(fcfd_pkg::SEP_RESET);
    set_idling(0, 0);
    hold_toggle <= ~hold_toggle;
    repeat (30) send_coded_byte();
  endtask

  // Saturate the byte and field counters, then copy a full-length prefix
  task automatic test_counter_saturation();
    logic [7:0] b;
    write_separator(fcfd_pkg::SEP_RESET);
    set_idling(31, 31);
    end_line();
    skip_prefix();
    repeat (66) begin
      b = 8'($urandom_range(255));
      while (b == sep_byte || b == fcfd_pkg::NEWLINE) b = 8'($urandom_range(255));
      send_item(b, 1'b0);
    end
    repeat (257) begin
      skip_prefix();
      send_item(sep_byte, 1'b0);
    end
    end_line();
    send_item(prefix_char(MAX_FIELD_LEN), 1'b0);
    repeat (10) send_coded_byte();
  endtask

  // Trigger one halting error, then check that nothing more comes out
  task automatic test_halt_on_error();
    int unsigned kind;
    write_separator(fcfd_pkg::SEP_RESET);
    set_idling(31, 31);
    kind = $urandom_range(3);
    case (kind)
      0: begin
        skip_prefix();
        send_item("x", 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
      end
      1: begin
        end_line();
        send_item(prefix_char(MAX_FIELD_LEN + 1 + $urandom_range(28)), 1'b0);
      end
      2: begin
        repeat (MAX_FIELDS + 1) begin
          skip_prefix();
          send_item(sep_byte, 1'b0);
        end
        end_line();
        repeat (MAX_FIELDS) begin
          send_item(fcfd_pkg::CH_ZERO, 1'b0);
          send_item(sep_byte, 1'b0);
        end
        send_item($urandom_range(1) ? 8'("1") : random_non_digit(), 1'b0);
      end
      default: begin
        end_line();
        if ($urandom_range(1) && saved_len[0] < MAX_FIELD_LEN)
          send_item(prefix_char(saved_len[0] + 1), 1'b0);
        else
          case ($urandom_range(2))
            0: send_item(sep_byte, 1'b0);
            1: send_item(fcfd_pkg::NEWLINE, 1'b0);
            default: send_item(random_non_digit(), 1'b0);
          endcase
      end
    endcase
    repeat (8) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest queued one
  always @(posedge clk) begin : check_result
    fcfd_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expansion_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: data %02h valid %b status %0d last %b",
                   out_tdata, out_tuser[0], out_tuser[2:1], out_tlast);
      end else begin
        want = expansion_q.pop_front();
        if (out_tdata !== want.data || out_tuser[0] !== want.byte_valid ||
            out_tuser[2:1] !== want.status || out_tlast !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch: expected data %02h valid %b status %0d last %b,",
                      " got data %02h valid %b status %0d last %b"},
                     want.data, want.byte_valid, want.status, want.last,
                     out_tdata, out_tuser[0], out_tuser[2:1], out_tlast);
        end
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_random_lines(fcfd_pkg::SEP_RESET, 0, 0, 30);
    test_random_lines(8'h00, 51, 0, 30);
    test_random_lines(8'hFF, 0, 51, 30);
    test_random_lines("5", 31, 31, 30);
    test_random_lines(fcfd_pkg::NEWLINE, 31, 31, 10);
    test_backpressure();
    test_counter_saturation();
    test_halt_on_error();

    // Let any late or stray result show up
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expansion_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
